// ===== hw/rtl/lcwc_pkg.sv =====
// Shared types and constants for the load cell weight conditioner.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package lcwc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int WEIGHT_W  = 21;
  localparam int NET_W     = 25;
  localparam int GAIN_W    = 36;
  localparam int GAIN_LO_W = 18;
  localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
  localparam int DB_W      = 8;
  localparam int FRAC_W    = 32;
  localparam int PROD_W    = NET_W + GAIN_W;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_READ_SAMPLES = 5;
  localparam int DEF_TARE_SAMPLES = 20;
  localparam int DEF_QUEUE_DEPTH  = 4;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = -36'sd39038060;
  localparam logic [DB_W-1:0]          DB_RESET   = 8'd1;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 21'sd1048575;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -21'sd1048576;

  typedef enum logic {
    CMD_WEIGH = 1'b0,
    CMD_TARE  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_TARE = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN     = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_STREAM   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [DB_W-1:0]          deadband;
  } scale_cfg_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_tenths;
    logic signed [SAMPLE_W-1:0] average_count;
    logic signed [NET_W-1:0]    net_count;
    logic                       tare_done;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcwc_front.sv =====
// Front end: accepts samples and tare commands, sums averaging windows.
// Pushes one finished window sum per reading or tare; uses lcwc_pkg.
`default_nettype none

module lcwc_front
  import lcwc_pkg::*;
#(
  parameter int READ_SAMPLES = DEF_READ_SAMPLES,
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES,
  parameter int SUM_W        = SAMPLE_W + 5
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       stream_en_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       in_cmd_i,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_i,
  output logic                            push_o,
  output logic [SUM_W:0]                  push_data_o,
  input  wire logic                       queue_full_i
);

  localparam int WinMax = (READ_SAMPLES > TARE_SAMPLES) ? READ_SAMPLES : TARE_SAMPLES;
  localparam int CntW   = (WinMax > 1) ? $clog2(WinMax) : 1;
  localparam logic [CntW-1:0] ReadLast = CntW'(READ_SAMPLES - 1);
  localparam logic [CntW-1:0] TareLast = CntW'(TARE_SAMPLES - 1);

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_add;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    taring_q, taring_d;
  logic                    accept;
  kind_e                   push_kind;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum_add    = sum_q + {{(SUM_W-SAMPLE_W){in_sample_i[SAMPLE_W-1]}}, in_sample_i};

  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    taring_d  = taring_q;
    push_o    = 1'b0;
    push_kind = KIND_READ;
    if (accept) begin
      if (cmd_e'(in_cmd_i) == CMD_TARE) begin
        // restart the tare window, drop any partial sum
        taring_d = 1'b1;
        sum_d    = '0;
        cnt_d    = '0;
      end else if (taring_q) begin
        push_kind = KIND_TARE;
        if (cnt_q == TareLast) begin
          push_o   = 1'b1;
          taring_d = 1'b0;
          sum_d    = '0;
          cnt_d    = '0;
        end else begin
          sum_d = sum_add;
          cnt_d = cnt_q + 1'b1;
        end
      end else if (stream_en_i) begin
        if (cnt_q == ReadLast) begin
          push_o = 1'b1;
          sum_d  = '0;
          cnt_d  = '0;
        end else begin
          sum_d = sum_add;
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  assign push_data_o = {push_kind, sum_add};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      taring_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      taring_q <= taring_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcwc_queue.sv =====
// Short FIFO between the front end and the scaling pipeline.
// Flip-flop storage, one read and one write per cycle; uses lcwc_pkg.
`default_nettype none

module lcwc_queue
  import lcwc_pkg::*;
#(
  parameter int WIDTH = 30,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  assign full_o      = (cnt_q == CntFull);
  assign pop_valid_o = (cnt_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcwc_back.sv =====
// Back end: divides window sums, applies tare, gain, rounding and deadband.
// Six-stage stall-all pipeline feeding an output register; uses lcwc_pkg.
`default_nettype none

module lcwc_back
  import lcwc_pkg::*;
#(
  parameter int READ_SAMPLES = DEF_READ_SAMPLES,
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES,
  parameter int SUM_W        = SAMPLE_W + 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire scale_cfg_t  cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [SUM_W:0] in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output result_t          out_data_o
);

  // reciprocal constants: exact truncating division for |sum| < 2^SUM_W
  localparam int KRead   = SUM_W + $clog2(READ_SAMPLES);
  localparam int KTare   = SUM_W + $clog2(TARE_SAMPLES);
  localparam int RecipW  = SUM_W + 1;
  localparam int MulW    = SUM_W + RecipW;
  localparam logic [63:0] RecipReadFull =
    ((64'd1 << KRead) + 64'(READ_SAMPLES) - 64'd1) / 64'(READ_SAMPLES);
  localparam logic [63:0] RecipTareFull =
    ((64'd1 << KTare) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
  localparam logic [RecipW-1:0] RecipRead = RecipReadFull[RecipW-1:0];
  localparam logic [RecipW-1:0] RecipTare = RecipTareFull[RecipW-1:0];
  localparam int AbsW   = PROD_W - 1;
  localparam int PhW    = PROD_W - FRAC_W;
  localparam int MagW   = AbsW - FRAC_W;
  localparam int LimW   = PhW + 1;
  localparam int PpLoW  = NET_W + GAIN_LO_W + 1;
  localparam int PpHiW  = NET_W + GAIN_HI_W;
  localparam logic [AbsW-1:0] HalfLsb = AbsW'(64'd1 << (FRAC_W - 1));
  localparam logic [MagW-1:0] PosMagMax = MagW'(WEIGHT_MAX);
  localparam logic [MagW-1:0] NegMagMax = MagW'(WEIGHT_MAX) + MagW'(1);

  logic adv;

  // stage 1: magnitude times reciprocal
  kind_e                   in_kind;
  logic signed [SUM_W-1:0] in_sum;
  logic [SUM_W-1:0]        in_mag;
  logic [RecipW-1:0]       in_recip;
  logic [MulW-1:0]         in_prod;
  logic                    v1_q;
  kind_e                   r1_kind_q;
  logic                    r1_neg_q;
  logic [MulW-1:0]         r1_prod_q;

  // stage 2: quotient, tare offset, net count
  logic [MulW-1:0]            quot_full;
  logic [SAMPLE_W-1:0]        quot_mag;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [NET_W-1:0]    net;
  logic signed [SAMPLE_W-1:0] offset_q;
  logic                       v2_q;
  kind_e                      r2_kind_q;
  logic signed [SAMPLE_W-1:0] r2_avg_q;
  logic signed [NET_W-1:0]    r2_net_q;

  // stage 3: partial products
  logic signed [PpLoW-1:0]    pp_lo;
  logic signed [PpHiW-1:0]    pp_hi;
  logic                       v3_q;
  kind_e                      r3_kind_q;
  logic signed [SAMPLE_W-1:0] r3_avg_q;
  logic signed [NET_W-1:0]    r3_net_q;
  logic signed [PpLoW-1:0]    r3_pp_lo_q;
  logic signed [PpHiW-1:0]    r3_pp_hi_q;

  // stage 4: product
  logic signed [PROD_W-1:0]   prod;
  logic                       v4_q;
  kind_e                      r4_kind_q;
  logic signed [SAMPLE_W-1:0] r4_avg_q;
  logic signed [NET_W-1:0]    r4_net_q;
  logic signed [PROD_W-1:0]   r4_prod_q;

  // stage 5: magnitude and integer part
  logic [PROD_W-1:0]          prod_neg;
  logic                       v5_q;
  kind_e                      r5_kind_q;
  logic signed [SAMPLE_W-1:0] r5_avg_q;
  logic signed [NET_W-1:0]    r5_net_q;
  logic                       r5_neg_q;
  logic [AbsW-1:0]            r5_abs_q;
  logic signed [PhW-1:0]      r5_ph_q;
  logic                       r5_plz_q;

  // stage 6: round and saturate
  logic [AbsW-1:0]            rnd;
  logic [MagW-1:0]            rnd_mag;
  logic signed [WEIGHT_W-1:0] rounded;
  logic                       v6_q;
  kind_e                      r6_kind_q;
  logic signed [SAMPLE_W-1:0] r6_avg_q;
  logic signed [NET_W-1:0]    r6_net_q;
  logic signed [PhW-1:0]      r6_ph_q;
  logic                       r6_plz_q;
  logic signed [WEIGHT_W-1:0] r6_rnd_q;

  // commit
  logic signed [LimW-1:0]     ph_x, hi_lim, lo_lim;
  logic                       move;
  logic signed [WEIGHT_W-1:0] shown_q, shown_d;
  result_t                    res_d;
  logic                       out_valid_q;
  result_t                    out_data_q;

  // whole pipeline holds while the output register is full and stalled
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign in_kind  = kind_e'(in_data_i[SUM_W]);
  assign in_sum   = in_data_i[SUM_W-1:0];
  assign in_mag   = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
  assign in_recip = (in_kind == KIND_TARE) ? RecipTare : RecipRead;
  assign in_prod  = in_mag * in_recip;

  assign quot_full = (r1_kind_q == KIND_TARE) ? (r1_prod_q >> KTare) : (r1_prod_q >> KRead);
  assign quot_mag  = quot_full[SAMPLE_W-1:0];
  assign avg       = r1_neg_q ? $signed(-quot_mag) : $signed(quot_mag);
  // a tare passing here updates the offset before the next reading reaches it
  assign net       = $signed({avg[SAMPLE_W-1], avg}) - $signed({offset_q[SAMPLE_W-1], offset_q});

  assign pp_lo = r2_net_q * $signed({1'b0, cfg_i.gain[GAIN_LO_W-1:0]});
  assign pp_hi = r2_net_q * $signed(cfg_i.gain[GAIN_W-1:GAIN_LO_W]);

  assign prod = $signed({r3_pp_hi_q, {GAIN_LO_W{1'b0}}})
              + $signed({{(PROD_W-PpLoW){r3_pp_lo_q[PpLoW-1]}}, r3_pp_lo_q});

  assign prod_neg = -r4_prod_q;

  assign rnd     = r5_abs_q + HalfLsb;
  assign rnd_mag = rnd[AbsW-1:FRAC_W];
  always_comb begin
    if (!r5_neg_q && (rnd_mag > PosMagMax)) begin
      rounded = WEIGHT_MAX;
    end else if (r5_neg_q && (rnd_mag > NegMagMax)) begin
      rounded = WEIGHT_MIN;
    end else if (r5_neg_q) begin
      rounded = WEIGHT_W'(-rnd_mag);
    end else begin
      rounded = WEIGHT_W'(rnd_mag);
    end
  end

  // deadband test on the integer part: |prod - shown*2^32| >= deadband*2^32
  assign ph_x   = {r6_ph_q[PhW-1], r6_ph_q};
  assign hi_lim = LimW'(shown_q) + $signed({1'b0, (LimW-1)'(cfg_i.deadband)});
  assign lo_lim = LimW'(shown_q) - $signed({1'b0, (LimW-1)'(cfg_i.deadband)});
  assign move   = (ph_x >= hi_lim) || (ph_x < lo_lim) || ((ph_x == lo_lim) && r6_plz_q);

  always_comb begin
    shown_d = shown_q;
    res_d   = '0;
    if (r6_kind_q == KIND_TARE) begin
      shown_d             = '0;
      res_d.average_count = r6_avg_q;
      res_d.tare_done     = 1'b1;
    end else begin
      if (move) begin
        shown_d = r6_rnd_q;
      end
      res_d.weight_tenths = shown_d;
      res_d.average_count = r6_avg_q;
      res_d.net_count     = r6_net_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
      offset_q    <= '0;
      shown_q     <= '0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      out_valid_q <= v6_q;
      if (v1_q && (r1_kind_q == KIND_TARE)) begin
        offset_q <= avg;
      end
      if (v6_q) begin
        shown_q <= shown_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_kind_q  <= in_kind;
      r1_neg_q   <= in_sum[SUM_W-1];
      r1_prod_q  <= in_prod;
      r2_kind_q  <= r1_kind_q;
      r2_avg_q   <= avg;
      r2_net_q   <= net;
      r3_kind_q  <= r2_kind_q;
      r3_avg_q   <= r2_avg_q;
      r3_net_q   <= r2_net_q;
      r3_pp_lo_q <= pp_lo;
      r3_pp_hi_q <= pp_hi;
      r4_kind_q  <= r3_kind_q;
      r4_avg_q   <= r3_avg_q;
      r4_net_q   <= r3_net_q;
      r4_prod_q  <= prod;
      r5_kind_q  <= r4_kind_q;
      r5_avg_q   <= r4_avg_q;
      r5_net_q   <= r4_net_q;
      r5_neg_q   <= r4_prod_q[PROD_W-1];
      r5_abs_q   <= r4_prod_q[PROD_W-1] ? prod_neg[AbsW-1:0] : r4_prod_q[AbsW-1:0];
      r5_ph_q    <= r4_prod_q[PROD_W-1:FRAC_W];
      r5_plz_q   <= (r4_prod_q[FRAC_W-1:0] == '0);
      r6_kind_q  <= r5_kind_q;
      r6_avg_q   <= r5_avg_q;
      r6_net_q   <= r5_net_q;
      r6_ph_q    <= r5_ph_q;
      r6_plz_q   <= r5_plz_q;
      r6_rnd_q   <= rounded;
      if (v6_q) begin
        out_data_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/load_cell_weight_conditioner.sv =====
// Load cell weight conditioner: averaging, tare, gain, deadband and rounding.
// Top level; instantiates lcwc_front, lcwc_queue and lcwc_back, uses lcwc_pkg.
//
// Usage:
//   Slave stream carries one item per handshake: tuser is the command (weigh
//   sample or start of a tare window), tdata the signed 24-bit raw count.
//   Every READ_SAMPLES weigh samples make one reading; a tare command opens a
//   window of TARE_SAMPLES samples whose average becomes the tare offset.
//   Master stream carries one result per finished reading or tare window.
//   Configuration writes (gain, deadband, stream enable) go through the cfg
//   channel, which is always ready; write it only while the block is idle.
// Timing:
//   Throughput is one input item per cycle while the queue is not full. The
//   item that finished a window is written into the queue, then passes the
//   six pipeline stages (divide, tare subtract, two-part gain multiply,
//   magnitude, rounding) and the deadband commit into the output register.
// Reset:
//   Clears sums, counts, tare offset and shown weight; registers take their
//   defaults (gain -39038060, deadband 1, stream on).
// Backpressure:
//   With a result out and m_axis_tready_i low the back holds; the front keeps
//   taking items until the four-entry queue fills, then drops s_axis_tready_o.
`default_nettype none

module load_cell_weight_conditioner
  import lcwc_pkg::*;
#(
  parameter int READ_SAMPLES = DEF_READ_SAMPLES,
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [23:0]          s_axis_tdata_i,   // [23:0] sample
  input  wire logic                 s_axis_tuser_i,   // [0] command
  // output stream
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [71:0]               m_axis_tdata_o,   // [20:0] weight_tenths,
                                                      // [44:21] average_count,
                                                      // [69:45] net_count, [71:70] zero
  output logic                      m_axis_tuser_o,   // [0] tare_done
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [GAIN_W-1:0]    cfg_wdata_i
);

  localparam int WinMax = (READ_SAMPLES > TARE_SAMPLES) ? READ_SAMPLES : TARE_SAMPLES;
  localparam int SumW   = SAMPLE_W + $clog2(WinMax);

  scale_cfg_t   scale_cfg_q;
  logic         stream_en_q;
  logic         push;
  logic [SumW:0] push_data;
  logic         queue_full;
  logic         pop_valid;
  logic         pop_ready;
  logic [SumW:0] pop_data;
  result_t      result;

  // configuration registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_cfg_q.gain     <= GAIN_RESET;
      scale_cfg_q.deadband <= DB_RESET;
      stream_en_q          <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GAIN:     scale_cfg_q.gain     <= cfg_wdata_i;
        CFG_DEADBAND: scale_cfg_q.deadband <= cfg_wdata_i[DB_W-1:0];
        CFG_STREAM:   stream_en_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  lcwc_front #(
    .READ_SAMPLES (READ_SAMPLES),
    .TARE_SAMPLES (TARE_SAMPLES),
    .SUM_W        (SumW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stream_en_i  (stream_en_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_sample_i  (s_axis_tdata_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_full_i (queue_full)
  );

  lcwc_queue #(
    .WIDTH (SumW + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  lcwc_back #(
    .READ_SAMPLES (READ_SAMPLES),
    .TARE_SAMPLES (TARE_SAMPLES),
    .SUM_W        (SumW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg_q),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_data_i   (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (result)
  );

  // pack result fields, lowest first, padded to whole bytes
  assign m_axis_tdata_o = {2'b00, result.net_count, result.average_count,
                           result.weight_tenths};
  assign m_axis_tuser_o = result.tare_done;

endmodule

`default_nettype wire
